// File: src/xorshift_rng_draw_unit_assert.svh
// assertion macros used by the checker file
`ifndef XORSHIFT_RNG_DRAW_UNIT_ASSERT_SVH
`define XORSHIFT_RNG_DRAW_UNIT_ASSERT_SVH

// implication checked on every rising clock edge, quiet during reset
`define XRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define XRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/xrd_pkg.sv
// ----------------------------------------------------------------------------
// xrd_pkg
// types, constants and mixing functions for the xorshift draw unit
// ----------------------------------------------------------------------------
package xrd_pkg;

    localparam logic [2:0] CMD_RESEED   = 3'd0;
    localparam logic [2:0] CMD_RAW      = 3'd1;
    localparam logic [2:0] CMD_RANGE    = 3'd2;
    localparam logic [2:0] CMD_FRACTION = 3'd3;
    localparam logic [2:0] CMD_CHANCE   = 3'd4;

    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [63:0] STAR_MUL    = 64'h2545f4914f6cdd1d;
    localparam logic [63:0] SEED_OFFSET = 64'h000000009e3779b9;
    localparam logic [63:0] ZERO_ESCAPE = 64'h1d872b41c5e9f00d;
    localparam logic [24:0] ONE_FIXED   = 25'd16777216;
    // start value only, the back part mixes the zero seed straight after reset
    localparam logic [63:0] RESET_STATE = 64'h0;

    // job codes sent from the front to the back
    localparam logic [2:0] JOB_RESEED  = 3'd0;
    localparam logic [2:0] JOB_RAW     = 3'd1;
    localparam logic [2:0] JOB_RANGE   = 3'd2;
    localparam logic [2:0] JOB_FRAC    = 3'd3;
    localparam logic [2:0] JOB_CHANCE  = 3'd4;
    localparam logic [2:0] JOB_CONST   = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] seed_value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [24:0] probability;
    } draw_in_t;

    typedef struct packed {
        logic [31:0] raw_word;
        logic signed [31:0] range_value;
        logic [23:0] fraction;
        logic        hit;
    } draw_out_t;

    // classified job: what the back part must do
    typedef struct packed {
        logic [2:0]  job;
        logic [31:0] seed_value;
        logic [31:0] low;
        logic [31:0] span;
        logic        full_span;
        logic [23:0] probability;
        logic        const_hit;
        logic [31:0] const_range;
    } job_t;

endpackage

// File: src/xrd_front.sv
// ----------------------------------------------------------------------------
// xrd_front
// classifies each command into a job for the back part
// ----------------------------------------------------------------------------
module xrd_front (
    input  xrd_pkg::draw_in_t item,
    output xrd_pkg::job_t     job
);

    logic [31:0] lo_ob;
    logic [31:0] hi_ob;
    logic [31:0] span;

    assign lo_ob = item.range_low ^ 32'h8000_0000;
    assign hi_ob = item.range_high ^ 32'h8000_0000;
    assign span  = item.range_high - item.range_low + 32'd1;

    always_comb
    begin
        job             = '0;
        job.seed_value  = item.seed_value;
        job.low         = item.range_low;
        job.span        = span;
        job.full_span   = (span == 32'd0);
        job.probability = item.probability[23:0];
        unique case (item.command)
            xrd_pkg::CMD_RESEED:   job.job = xrd_pkg::JOB_RESEED;
            xrd_pkg::CMD_RAW:      job.job = xrd_pkg::JOB_RAW;
            xrd_pkg::CMD_FRACTION: job.job = xrd_pkg::JOB_FRAC;
            xrd_pkg::CMD_RANGE:
            begin
                if (hi_ob <= lo_ob)
                begin
                    job.job         = xrd_pkg::JOB_CONST;
                    job.const_range = item.range_low;
                end
                else
                begin
                    job.job = xrd_pkg::JOB_RANGE;
                end
            end
            xrd_pkg::CMD_CHANCE:
            begin
                if (item.probability == 25'd0)
                begin
                    job.job = xrd_pkg::JOB_CONST;
                end
                else if (item.probability >= xrd_pkg::ONE_FIXED)
                begin
                    job.job       = xrd_pkg::JOB_CONST;
                    job.const_hit = 1'b1;
                end
                else
                begin
                    job.job = xrd_pkg::JOB_CHANCE;
                end
            end
            default: job.job = xrd_pkg::JOB_CONST;
        endcase
    end

endmodule

// File: src/xrd_queue.sv
// ----------------------------------------------------------------------------
// xrd_queue
// small queue of classified jobs between front and back
// ----------------------------------------------------------------------------
module xrd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  xrd_pkg::job_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output xrd_pkg::job_t  rd_data,
    output logic           empty
);

    xrd_pkg::job_t entry_reg [xrd_pkg::QUEUE_DEPTH];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
        end
    end

endmodule

// File: src/xrd_back.sv
// ----------------------------------------------------------------------------
// xrd_back
// generator state, step, multiplies and bit-serial modulo
// ----------------------------------------------------------------------------
module xrd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    input  xrd_pkg::job_t      job,
    output logic               job_pop,
    output logic               empty,
    input  logic               pop,
    output xrd_pkg::draw_out_t result
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_M1    = 4'd1;  // seed * star + offset
    localparam logic [3:0] ST_M2    = 4'd2;  // mix multiply a
    localparam logic [3:0] ST_M3    = 4'd3;  // mix multiply b
    localparam logic [3:0] ST_M4    = 4'd4;  // final xor, load state
    localparam logic [3:0] ST_STEP  = 4'd5;
    localparam logic [3:0] ST_STAR  = 4'd6;  // draw multiply
    localparam logic [3:0] ST_DRAW  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;
    localparam logic [3:0] ST_RESET = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [63:0] gen_reg, gen_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  part_reg, part_next;
    xrd_pkg::job_t job_reg, job_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  bit_reg, bit_next;
    logic        out_valid_reg, out_valid_next;
    xrd_pkg::draw_out_t out_reg, out_next;
    logic        busy_is_reset_reg, busy_is_reset_next;

    // 64x64 low-half product in three 32x32 slices: mul_a * mul_b
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [31:0] sl_a;
    logic [31:0] sl_b;
    logic [63:0] sl_prod;
    logic [63:0] step1;
    logic [63:0] step2;
    logic [63:0] step3;
    logic [32:0] trial;
    logic [31:0] draw;

    assign step1 = gen_reg ^ (gen_reg >> 12);
    assign step2 = step1 ^ (step1 << 25);
    assign step3 = step2 ^ (step2 >> 27);
    assign draw  = acc_reg[63:32];

    assign sl_prod = {32'd0, sl_a} * {32'd0, sl_b};

    always_comb
    begin
        unique case (part_reg)
            2'd0:    begin sl_a = mul_a[31:0];  sl_b = mul_b[31:0];  end
            2'd1:    begin sl_a = mul_a[63:32]; sl_b = mul_b[31:0];  end
            2'd2:    begin sl_a = mul_a[31:0];  sl_b = mul_b[63:32]; end
            default: begin sl_a = 32'd0;        sl_b = 32'd0;        end
        endcase
    end

    // multiply operands, held stable by src_reg across the slices
    logic [63:0] src_reg, src_next;

    always_comb
    begin
        mul_a = src_reg;
        mul_b = xrd_pkg::STAR_MUL;
        unique case (state_reg)
            ST_M2:   mul_b = xrd_pkg::MIX_MUL_A;
            ST_M3:   mul_b = xrd_pkg::MIX_MUL_B;
            default: mul_b = xrd_pkg::STAR_MUL;
        endcase
    end

    assign job_pop = (state_reg == ST_IDLE) && !job_empty && !out_valid_reg;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign trial   = {rem_reg, quo_reg[31]} - {1'b0, job_reg.span};

    always_comb
    begin
        state_next         = state_reg;
        gen_next           = gen_reg;
        acc_next           = acc_reg;
        part_next          = part_reg;
        job_next           = job_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        bit_next           = bit_reg;
        out_valid_next     = out_valid_reg;
        out_next           = out_reg;
        src_next           = src_reg;
        busy_is_reset_next = busy_is_reset_reg;

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RESET:
            begin
                job_next.job        = xrd_pkg::JOB_RESEED;
                src_next            = xrd_pkg::SEED_OFFSET;
                busy_is_reset_next  = 1'b1;
                acc_next            = '0;
                part_next           = 2'd0;
                state_next          = ST_M2;
                src_next            = xrd_pkg::SEED_OFFSET ^ (xrd_pkg::SEED_OFFSET >> 30);
            end
            ST_IDLE:
            begin
                if (job_pop)
                begin
                    job_next  = job;
                    acc_next  = '0;
                    part_next = 2'd0;
                    out_next  = '0;
                    unique case (job.job)
                        xrd_pkg::JOB_RESEED:
                        begin
                            src_next   = {32'd0, job.seed_value};
                            state_next = ST_M1;
                        end
                        xrd_pkg::JOB_CONST:
                        begin
                            out_next.range_value = job.const_range;
                            out_next.hit         = job.const_hit;
                            out_valid_next       = 1'b1;
                        end
                        default: state_next = ST_STEP;
                    endcase
                end
            end
            ST_M1, ST_M2, ST_M3, ST_STAR:
            begin
                if (part_reg == 2'd0)
                begin
                    acc_next = sl_prod;
                end
                else
                begin
                    acc_next = acc_reg + {sl_prod[31:0], 32'd0};
                end
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd2)
                begin
                    part_next = 2'd0;
                    unique case (state_reg)
                        ST_M1:
                        begin
                            src_next   = (acc_next + xrd_pkg::SEED_OFFSET)
                                       ^ ((acc_next + xrd_pkg::SEED_OFFSET) >> 30);
                            state_next = ST_M2;
                        end
                        ST_M2:
                        begin
                            src_next   = acc_next ^ (acc_next >> 27);
                            state_next = ST_M3;
                        end
                        ST_M3:   state_next = ST_M4;
                        default: state_next = ST_DRAW;
                    endcase
                end
            end
            ST_M4:
            begin
                gen_next = acc_reg ^ (acc_reg >> 31);
                if (gen_next == 64'd0)
                begin
                    gen_next = xrd_pkg::ZERO_ESCAPE;
                end
                if (busy_is_reset_reg)
                begin
                    busy_is_reset_next = 1'b0;
                end
                else
                begin
                    out_next       = '0;
                    out_valid_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_STEP:
            begin
                gen_next   = step3;
                src_next   = step3;
                state_next = ST_STAR;
            end
            ST_DRAW:
            begin
                state_next = ST_DONE;
                unique case (job_reg.job)
                    xrd_pkg::JOB_RAW:  out_next.raw_word = draw;
                    xrd_pkg::JOB_FRAC: out_next.fraction = draw[31:8];
                    xrd_pkg::JOB_CHANCE:
                        out_next.hit = (draw[31:8] < job_reg.probability);
                    xrd_pkg::JOB_RANGE:
                    begin
                        if (job_reg.full_span)
                        begin
                            out_next.range_value = job_reg.low + draw;
                        end
                        else
                        begin
                            rem_next   = '0;
                            quo_next   = draw;
                            bit_next   = 5'd0;
                            state_next = ST_DIV;
                        end
                    end
                    default: out_next = '0;
                endcase
            end
            ST_DIV:
            begin
                // restoring remainder, one dividend bit a cycle
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                end
                quo_next = {quo_reg[30:0], 1'b0};
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd31)
                begin
                    out_next.range_value = job_reg.low + rem_next;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        job_reg  <= job_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        out_reg  <= out_next;
        src_reg  <= src_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_RESET;
            gen_reg           <= xrd_pkg::RESET_STATE;
            part_reg          <= 2'd0;
            bit_reg           <= 5'd0;
            out_valid_reg     <= 1'b0;
            busy_is_reset_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            gen_reg           <= gen_next;
            part_reg          <= part_next;
            bit_reg           <= bit_next;
            out_valid_reg     <= out_valid_next;
            busy_is_reset_reg <= busy_is_reset_next;
        end
    end

endmodule

// File: src/xorshift_rng_draw_unit.sv
// ----------------------------------------------------------------------------
// xorshift_rng_draw_unit
// xorshift64* generator with splitmix64 seeding, one result per command
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  command | in  | push / full       | cmd (xrd_pkg::draw_in_t)
//  result  | out | pop / empty       | res (xrd_pkg::draw_out_t)
//
// a draw runs one step and three 32x32 multiply slices
// a range draw short of the full span adds the bit-serial remainder unit
// a reseed runs three sliced 64-bit multiplies
// after reset the back part mixes the zero seed
// a job queue of two lets commands be taken while the back part works
// ----------------------------------------------------------------------------
module xorshift_rng_draw_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  xrd_pkg::draw_in_t  cmd,
    output logic               empty,
    input  logic               pop,
    output xrd_pkg::draw_out_t res
);

    xrd_pkg::job_t front_job;
    xrd_pkg::job_t queue_job;
    logic          queue_empty;
    logic          queue_pop;

    // classify the incoming command
    xrd_front u_front (
        .item (cmd),
        .job  (front_job)
    );

    // decouple front and back
    xrd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_job),
        .full    (full),
        .rd_en   (queue_pop),
        .rd_data (queue_job),
        .empty   (queue_empty)
    );

    // state, multiplies and remainder unit
    xrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (queue_empty),
        .job       (queue_job),
        .job_pop   (queue_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (res)
    );

endmodule

// File: src/xrd_checker.sv
// ----------------------------------------------------------------------------
// xrd_checker
// port-level checks on the draw unit
// ----------------------------------------------------------------------------
`include "xorshift_rng_draw_unit_assert.svh"

module xrd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input xrd_pkg::draw_out_t res
);

    `XRD_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(res), "result changed while waiting")
    `XRD_ASSERT_IMP(a_one_field, clk, rst_n, !empty, $countones({res.raw_word != 32'd0, res.fraction != 24'd0, res.hit}) <= 1, "more than one draw field set")
    `XRD_ASSERT_NEXT(a_pop_clears, clk, rst_n, !empty && pop, empty, "result shown twice")

endmodule

bind xorshift_rng_draw_unit xrd_checker u_xrd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .res   (res)
);
